// File: rtl/edge_truncated_window_average_assert.svh
// assertion macros for the checker file of the window average block
// no dependencies; included by bare file name
`ifndef EDGE_TRUNCATED_WINDOW_AVERAGE_ASSERT_SVH
`define EDGE_TRUNCATED_WINDOW_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ETWA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ETWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/etwa_pkg.sv
// shared types and constants of the edge-truncated window average block
// no dependencies
package etwa_pkg;

   // field widths
   localparam int SAMPLE_W    = 32;
   localparam int AVG_W       = 32;
   localparam int STEP_W      = 32;
   localparam int WIDTH_W     = 5;
   localparam int ALIGN_W     = 2;
   localparam int LENGTH_W    = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   // default largest window width; legal range 1 to 256
   localparam int ETWA_MAX_WIDTH = 16;

   // quotient bits resolved per divider cycle
   localparam int DIGIT_BITS = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALIGNMENT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERIES_LENGTH = 2'd2;

   // alignment codes
   localparam logic [ALIGN_W-1:0] ALIGN_BACKWARD = 2'd0;
   localparam logic [ALIGN_W-1:0] ALIGN_FORWARD  = 2'd1;
   localparam logic [ALIGN_W-1:0] ALIGN_CENTERED = 2'd2;

   // register reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 5'd3;
   localparam logic [ALIGN_W-1:0]  ALIGN_RESET  = ALIGN_BACKWARD;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 32'd1;

   // control from the sequencer to the divider
   typedef struct packed {
      logic start;
      logic negate;
   } div_ctl_type;

endpackage

// File: rtl/etwa_cell.sv
// one cell of the sample chain: holds a sample, takes its neighbor's on shift
// depends on etwa_pkg
module etwa_cell
   import etwa_pkg::*;
(
   input  logic                       clock,
   input  logic                       shift,
   input  logic signed [SAMPLE_W-1:0] data_in,
   output logic signed [SAMPLE_W-1:0] data_out
);

   logic signed [SAMPLE_W-1:0] data_ff;

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// File: rtl/etwa_divider.sv
// iterative unsigned divider, DIGIT_BITS quotient bits per cycle, signed result
// depends on etwa_pkg
module etwa_divider
   import etwa_pkg::*;
#(
   parameter int MAG_W = 37,
   parameter int CNT_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  div_ctl_type             ctl,
   input  logic [MAG_W-1:0]        dividend,
   input  logic [CNT_W-1:0]        divisor,
   output logic                    done,
   output logic signed [AVG_W-1:0] quotient
);

   localparam int STEPS   = (MAG_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int Q_W     = STEPS * DIGIT_BITS;
   localparam int STEPS_W = $clog2(STEPS + 1);

   logic [Q_W-1:0]     work_ff, work_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   div_ff;
   logic               neg_ff;
   logic [STEPS_W-1:0] steps_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [AVG_W-1:0]   quo_ff, quo_in;
   logic [CNT_W:0]     part;
   logic [Q_W-1:0]     shift_word;
   logic               final_step;

   // restoring division over one digit
   always_comb begin
      part       = {1'b0, rem_ff};
      shift_word = work_ff;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         part       = {part[CNT_W-1:0], shift_word[Q_W-1]};
         shift_word = {shift_word[Q_W-2:0], 1'b0};
         if (part >= {1'b0, div_ff}) begin
            part          = part - {1'b0, div_ff};
            shift_word[0] = 1'b1;
         end
      end
      rem_in  = part[CNT_W-1:0];
      work_in = shift_word;
   end

   // sign applied to the truncated magnitude
   assign quo_in     = neg_ff ? -work_in[AVG_W-1:0] : work_in[AVG_W-1:0];
   assign final_step = busy_ff && (steps_ff == STEPS_W'(1));

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         done_ff <= final_step;
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            steps_ff <= STEPS_W'(STEPS);
         end else if (busy_ff) begin
            steps_ff <= steps_ff - STEPS_W'(1);
            if (final_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         work_ff <= Q_W'(dividend);
         rem_ff  <= '0;
         div_ff  <= divisor;
         neg_ff  <= ctl.negate;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         if (final_step) begin
            quo_ff <= quo_in;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/edge_truncated_window_average.sv
// Edge-truncated moving average over a time series of signed samples.
// Input channel req_: one sample word per time step, in order; step 0 is the
// first word after reset or after the word that ends a series.
// Result channel rsp_: window mean (truncated toward zero), its time step, and
// a flag on the last result caused by one input word.
// Config port csr_: write enable, index and data; write only while idle.
// Backward windows give one result per input at once; forward and centered
// results come late, and the word for the last step flushes every pending
// step, up to 16 results.
// Each result sums the samples inside its window one by one over the cell
// chain, then runs the digit-serial divider. A word that completes no window
// is taken and done without leaving the idle state.
// req_ready is high only when no result is being computed; a result waiting
// in the output register does not block the next input word. When the
// receiver stalls, computation of the next result stops at its output.
// Reset (synchronous) empties the pipeline, restarts at step 0 and restores
// width 3, backward alignment and series length 1; sample cells are not
// cleared.
// depends on etwa_pkg, etwa_cell, etwa_divider
module edge_truncated_window_average
   import etwa_pkg::*;
#(
   parameter int MAX_WIDTH = ETWA_MAX_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [AVG_W-1:0]    rsp_average,
   output logic [STEP_W-1:0]          rsp_out_step,
   output logic                       rsp_run_last,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // oldest age ever read; a 5-bit width caps it at 30
   localparam int MAX_AGE = (MAX_WIDTH < 30) ? MAX_WIDTH : 30;
   localparam int STORE_D = MAX_AGE + 1;
   localparam int AGE_W   = $clog2(STORE_D);
   localparam int CNT_W   = $clog2(STORE_D + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(STORE_D);
   localparam int MAG_W   = SUM_W;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_START    = 6'b000010,
      S_ACCUM    = 6'b000100,
      S_DIV_GO   = 6'b001000,
      S_DIV_WAIT = 6'b010000,
      S_EMIT     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [WIDTH_W-1:0]  width_ff;
   logic [ALIGN_W-1:0]  align_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [STEP_W-1:0]   step_ff;

   logic [WIDTH_W-1:0]  w_eff, before_c, after_c, d0;
   logic [LENGTH_W-1:0] len_m1;
   logic                accept, is_last, has_result;

   logic [STEP_W-1:0]   s_ff, t_ff;
   logic [WIDTH_W-1:0]  d_ff, dstop_ff, before_ff, after_ff;
   logic [AGE_W-1:0]    age_ff, age_end_ff, age_lo_c, age_hi_c;
   logic [WIDTH_W:0]    reach_c;
   logic [CNT_W-1:0]    cnt_ff, cnt_c;
   logic signed [SUM_W-1:0] acc_ff;
   logic [MAG_W-1:0]    mag_c;
   logic                final_c, emit_load;

   logic signed [SAMPLE_W-1:0] store [STORE_D];

   div_ctl_type             div_ctl;
   logic                    div_done;
   logic signed [AVG_W-1:0] div_quotient;

   logic                    rsp_valid_ff;
   logic signed [AVG_W-1:0] avg_ff;
   logic [STEP_W-1:0]       out_step_ff;
   logic                    run_last_ff;

   // effective width, alignment and series end
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      unique case (align_ff)
         ALIGN_FORWARD: begin
            before_c = '0;
            after_c  = w_eff - WIDTH_W'(1);
         end
         ALIGN_CENTERED: begin
            before_c = w_eff >> 1;
            after_c  = w_eff >> 1;
         end
         default: begin
            before_c = w_eff - WIDTH_W'(1);
            after_c  = '0;
         end
      endcase
   end

   assign len_m1     = (length_ff == '0) ? '0 : length_ff - LENGTH_W'(1);
   assign accept     = req_valid && req_ready;
   assign is_last    = step_ff >= len_m1;
   assign has_result = is_last || (step_ff >= STEP_W'(after_c));
   // distance from the current step back to the first step to emit
   assign d0         = (step_ff >= STEP_W'(after_c)) ? after_c : step_ff[WIDTH_W-1:0];

   // sample chain, newest in cell 0
   for (genvar i = 0; i < STORE_D; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] link;
      if (i == 0) begin : g_head
         assign link = req_sample;
      end else begin : g_link
         assign link = store[i-1];
      end
      etwa_cell u_cell (
         .clock    (clock),
         .shift    (accept),
         .data_in  (link),
         .data_out (store[i])
      );
   end

   // window ages of the step being worked on, clipped to the series
   assign age_lo_c = (d_ff > after_ff) ? AGE_W'(d_ff - after_ff) : '0;
   assign reach_c  = {1'b0, d_ff} + {1'b0, before_ff};
   assign age_hi_c = (s_ff >= STEP_W'(before_ff)) ? AGE_W'(reach_c) : AGE_W'(t_ff);
   assign cnt_c    = CNT_W'(age_hi_c - age_lo_c) + CNT_W'(1);

   // magnitude and sign for the divider
   assign mag_c          = acc_ff[SUM_W-1] ? MAG_W'(-acc_ff) : MAG_W'(acc_ff);
   assign div_ctl.start  = (state_ff == S_DIV_GO);
   assign div_ctl.negate = acc_ff[SUM_W-1];

   etwa_divider #(
      .MAG_W (MAG_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (mag_c),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign final_c   = (d_ff == dstop_ff);
   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && has_result) begin
               state_in = S_START;
            end
         end
         S_START: state_in = S_ACCUM;
         S_ACCUM: begin
            if (age_ff == age_end_ff) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               state_in = final_c ? S_IDLE : S_START;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         align_ff     <= ALIGN_RESET;
         length_ff    <= LENGTH_RESET;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            step_ff <= is_last ? '0 : step_ff + STEP_W'(1);
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_WINDOW_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
               CSR_ALIGNMENT:     align_ff  <= csr_wdata[ALIGN_W-1:0];
               CSR_SERIES_LENGTH: length_ff <= csr_wdata[LENGTH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff      <= step_ff;
         s_ff      <= step_ff - STEP_W'(d0);
         d_ff      <= d0;
         dstop_ff  <= is_last ? '0 : d0;
         before_ff <= before_c;
         after_ff  <= after_c;
      end
      if (state_ff == S_START) begin
         age_ff     <= age_lo_c;
         age_end_ff <= age_hi_c;
         cnt_ff     <= cnt_c;
         acc_ff     <= '0;
      end
      if (state_ff == S_ACCUM) begin
         acc_ff <= acc_ff + SUM_W'(store[age_ff]);
         age_ff <= age_ff + AGE_W'(1);
      end
      if (emit_load) begin
         avg_ff      <= div_quotient;
         out_step_ff <= s_ff;
         run_last_ff <= final_c;
         if (!final_c) begin
            d_ff <= d_ff - WIDTH_W'(1);
            s_ff <= s_ff + STEP_W'(1);
         end
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_average  = avg_ff;
   assign rsp_out_step = out_step_ff;
   assign rsp_run_last = run_last_ff;

endmodule

// File: rtl/etwa_checker.sv
// port-level checks of the window average block, bound to the top level
// depends on etwa_pkg, edge_truncated_window_average_assert.svh and the top level
`include "edge_truncated_window_average_assert.svh"

module etwa_checker
   import etwa_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [AVG_W-1:0] rsp_average,
   input logic [STEP_W-1:0]       rsp_out_step,
   input logic                    rsp_run_last
);

   // a stalled result word holds
   `ETWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average) && $stable(rsp_out_step) && $stable(rsp_run_last), "stalled result changed")

   // more results of this input still to come, so no new input is taken
   `ETWA_ASSERT_IMPL(a_busy_mid_run, clock, reset, rsp_valid && !rsp_run_last, !req_ready, "input taken in the middle of a result run")

   // a result only appears out of a busy cycle
   `ETWA_ASSERT_IMPL(a_rise_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "result appeared while idle")

   // reset leaves no result pending
   `ETWA_ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_valid && req_ready, "result pending after reset")

endmodule

bind edge_truncated_window_average etwa_checker u_checker (.*);

// File: dv/edge_truncated_window_average_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the edge-truncated window average block
// depends on etwa_pkg and edge_truncated_window_average
module edge_truncated_window_average_tb;
   import etwa_pkg::*;

   localparam int STORE_DEPTH = ETWA_MAX_WIDTH + 1;
   localparam int HIST_W = $clog2(STORE_DEPTH);
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_WORDS = 175;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [ALIGN_W-1:0] ALIGN_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFFFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [AVG_W-1:0] average;
      logic [STEP_W-1:0]       step;
      logic                    run_last;
   } window_mean_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [AVG_W-1:0]    rsp_average;
   logic [STEP_W-1:0]          rsp_out_step;
   logic                       rsp_run_last;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // predictor state: settings, recent samples (newest first), next step
   logic [WIDTH_W-1:0]         cfg_width = WIDTH_RESET;
   logic [ALIGN_W-1:0]         cfg_align = ALIGN_RESET;
   logic [LENGTH_W-1:0]        cfg_length = LENGTH_RESET;
   logic signed [SAMPLE_W-1:0] sample_hist [STORE_DEPTH];
   logic [STEP_W-1:0]          next_step = '0;
   window_mean_type            expected_means [$];

   int          mismatch_count = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;
   int unsigned cycle_count = 0;

   edge_truncated_window_average uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_average  (rsp_average),
      .rsp_out_step (rsp_out_step),
      .rsp_run_last (rsp_run_last),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // idle length: mostly short, a few long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return $urandom_range(1, 3);
      if (pick < 9) return $urandom_range(4, 8);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return $urandom_range(0, 15);
         3: return -$signed(SAMPLE_W'($urandom_range(1, 15)));
         default: return $urandom;
      endcase
   endfunction

   // expected means caused by one sample word
   task automatic predict_means(input logic signed [SAMPLE_W-1:0] value);
      longint unsigned span, len, lag, lead, t, from_step, stop, s, lo, hi, k;
      longint sum, term, avg;
      bit ends;
      window_mean_type mean;
      span = 64'(cfg_width);
      if (span < 1) span = 1;
      if (span > ETWA_MAX_WIDTH) span = ETWA_MAX_WIDTH;
      len = 64'(cfg_length);
      if (len < 1) len = 1;
      case (cfg_align)
         ALIGN_FORWARD: begin
            lag = 0;
            lead = span - 1;
         end
         ALIGN_CENTERED: begin
            lag = span / 2;
            lead = span / 2;
         end
         default: begin
            lag = span - 1;
            lead = 0;
         end
      endcase
      for (int i = STORE_DEPTH - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
      sample_hist[0] = value;
      t = 64'(next_step);
      ends = (t >= len - 1);
      from_step = (t >= lead) ? t - lead : 0;
      if (ends || t >= lead) begin
         stop = ends ? t : from_step;
         for (s = from_step; s <= stop; s++) begin
            lo = (s >= lag) ? s - lag : 0;
            hi = (s + lead < t) ? s + lead : t;
            sum = 0;
            for (k = lo; k <= hi; k++) begin
               if (t - k < STORE_DEPTH) begin
                  term = longint'(sample_hist[HIST_W'(t - k)]);
                  sum += term;
               end
            end
            avg = sum / longint'(hi - lo + 1);
            mean.average = avg[AVG_W-1:0];
            mean.step = s[STEP_W-1:0];
            mean.run_last = (s == stop);
            expected_means = {expected_means, mean};
         end
      end
      next_step = ends ? '0 : STEP_W'(t + 1);
   endtask

   // send one sample word, with a random gap ahead of it
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      predict_means(value);
   endtask

   // stop sending and let every pending mean come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_WINDOW_WIDTH:  cfg_width = data[WIDTH_W-1:0];
         CSR_ALIGNMENT:     cfg_align = data[ALIGN_W-1:0];
         CSR_SERIES_LENGTH: cfg_length = data;
         default: ;
      endcase
   endtask

   // write all settings; noisy fills unused width and alignment data bits and sometimes hits the spare index
   task automatic configure(input logic [WIDTH_W-1:0] span,
                            input logic [ALIGN_W-1:0] align,
                            input logic [LENGTH_W-1:0] length, input bit noisy);
      logic [CSR_DATA_W-1:0] data;
      wait_drained();
      data = noisy ? $urandom : '0;
      data[WIDTH_W-1:0] = span;
      write_csr(CSR_WINDOW_WIDTH, data);
      data = noisy ? $urandom : '0;
      data[ALIGN_W-1:0] = align;
      write_csr(CSR_ALIGNMENT, data);
      write_csr(CSR_SERIES_LENGTH, length);
      if (noisy && $urandom_range(0, 2) == 0) write_csr(CSR_UNUSED, $urandom);
      csr_write <= 1'b0;
   endtask

   // result receiver with random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each accepted result word with the oldest expected mean
   always @(posedge clock) begin
      window_mean_type mean;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected mean: avg %0d step %0d last %0b",
                        rsp_average, rsp_out_step, rsp_run_last);
         end else begin
            mean = expected_means.pop_front();
            if (rsp_average !== mean.average || rsp_out_step !== mean.step ||
                rsp_run_last !== mean.run_last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mean mismatch: expected avg %0d step %0d last %0b, ",
                            "got avg %0d step %0d last %0b"},
                           mean.average, mean.step, mean.run_last,
                           rsp_average, rsp_out_step, rsp_run_last);
            end
         end
      end
   end

   // reset settings: each word is a series of its own
   task automatic test_reset_values();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-1);
   endtask

   // backward window clipped at step 0, extreme sums
   task automatic test_backward_clipping();
      configure(5'd4, ALIGN_BACKWARD, 32'd5, 1'b0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
   endtask

   // forward window: late results, flush on the last step
   task automatic test_forward_flush();
      configure(5'd3, ALIGN_FORWARD, 32'd5, 1'b0);
      send_sample(7);
      send_sample(-7);
      send_sample(3);
      send_sample(-2);
      send_sample(5);
   endtask

   // centered window with even width spans width+1 samples
   task automatic test_centered_even_width();
      configure(5'd4, ALIGN_CENTERED, 32'd6, 1'b0);
      send_sample(-1);
      send_sample(1);
      send_sample(-3);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(2);
   endtask

   // zero width, spare alignment code, empty series, oversized width
   task automatic test_out_of_range_settings();
      configure(5'd0, ALIGN_UNUSED, 32'd0, 1'b0);
      send_sample(-5);
      send_sample(9);
      configure(5'd31, ALIGN_FORWARD, 32'd3, 1'b0);
      send_sample(SAMPLE_MIN);
      send_sample(1);
      send_sample(-2);
   endtask

   // random settings per phase; phases may end mid-series
   task automatic test_random_series();
      int words_sent, phase_words, pick;
      logic [WIDTH_W-1:0] span;
      logic [ALIGN_W-1:0] align;
      logic [LENGTH_W-1:0] length;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: span = 5'd0;
            1: span = WIDTH_W'($urandom_range(17, 31));
            2: span = 5'd16;
            3: span = 5'd1;
            default: span = WIDTH_W'($urandom_range(1, 16));
         endcase
         align = ($urandom_range(0, 9) == 0) ? ALIGN_UNUSED :
                 ALIGN_W'($urandom_range(0, 2));
         pick = $urandom_range(0, 9);
         case (pick)
            0: length = '0;
            1: length = '1;
            2: length = $urandom;
            default: length = $urandom_range(1, 24);
         endcase
         configure(span, align, length, $urandom_range(0, 2) == 0);
         calm = ($urandom_range(0, 3) == 0);
         phase_words = $urandom_range(4, 30);
         repeat (phase_words) send_sample(pick_sample());
         words_sent += phase_words;
      end
      calm = 1'b0;
   endtask

   initial begin
      foreach (sample_hist[i]) sample_hist[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_backward_clipping();
      test_forward_flush();
      test_centered_even_width();
      test_out_of_range_settings();
      test_random_series();
      wait_drained();
      if (mismatch_count == 0 && expected_means.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
